// ===== src/pom_pkg.sv =====
`timescale 1ns / 1ps

package pom_pkg;

    // Width of the modulus, the exponent field and the result
    localparam int VAL_W = 31;
    // Stream data width: value field padded to whole bytes
    localparam int DATA_W = 32;
    // Bit counter over one modular product
    localparam int CNT_W = $clog2(VAL_W);
    // Default number of exponent bits scanned
    localparam int EXPONENT_BITS_DEF = 31;
    // Modulus after reset
    localparam logic [VAL_W-1:0] MODULUS_RESET = VAL_W'(1000000007);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // take a new exponent, set up accumulator and base
        logic mul_start; // clear partial products, load the multiplier shifter
        logic mul_step;  // one bit of both interleaved products
        logic commit;    // write back products, shift the exponent
        logic push;      // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic exp_zero;  // no set exponent bits left
        logic out_free;  // output register can take a result this cycle
    } t_status;

endpackage

// ===== src/pom_dp.sv =====
`timescale 1ns / 1ps

module pom_dp #(
    parameter int EXPONENT_BITS = pom_pkg::EXPONENT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pom_pkg::t_cmd              i_cmd,
    output pom_pkg::t_status           o_status,
    input  logic [pom_pkg::VAL_W-1:0]  i_exponent,
    input  logic                       i_cfg_valid,
    input  logic [pom_pkg::VAL_W-1:0]  i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [pom_pkg::VAL_W-1:0]  o_out_data
);

    // Exponent bits that can ever be set within the input field
    localparam int SCAN_BITS = (EXPONENT_BITS < pom_pkg::VAL_W) ? EXPONENT_BITS
                                                                : pom_pkg::VAL_W;

    // One interleaved step: (2r + a) mod m, with r and a both below m
    function automatic logic [pom_pkg::VAL_W-1:0] mod_dbl_add(
        input logic [pom_pkg::VAL_W-1:0] r,
        input logic [pom_pkg::VAL_W-1:0] a,
        input logic [pom_pkg::VAL_W-1:0] m
    );
        logic [pom_pkg::VAL_W+1:0] t;
        logic [pom_pkg::VAL_W+1:0] m1;
        logic [pom_pkg::VAL_W+1:0] m2;
        logic [pom_pkg::VAL_W+1:0] res;
        t   = {1'b0, r, 1'b0} + {2'b00, a};
        m1  = {2'b00, m};
        m2  = {1'b0, m, 1'b0};
        if (t >= m2) begin
            res = t - m2;
        end else if (t >= m1) begin
            res = t - m1;
        end else begin
            res = t;
        end
        return res[pom_pkg::VAL_W-1:0];
    endfunction

    logic [pom_pkg::VAL_W-1:0] r_modulus;
    logic [SCAN_BITS-1:0]      r_exp;
    logic [pom_pkg::VAL_W-1:0] r_acc;
    logic [pom_pkg::VAL_W-1:0] r_base;
    logic [pom_pkg::VAL_W-1:0] r_pacc;
    logic [pom_pkg::VAL_W-1:0] r_pbase;
    logic [pom_pkg::VAL_W-1:0] r_shift;
    logic                      r_out_valid;
    logic [pom_pkg::VAL_W-1:0] r_out_data;

    logic                      mod_small;
    logic                      mul_bit;
    logic [pom_pkg::VAL_W-1:0] n_pacc;
    logic [pom_pkg::VAL_W-1:0] n_pbase;

    assign mod_small = (r_modulus < pom_pkg::VAL_W'(2));
    assign mul_bit   = r_shift[pom_pkg::VAL_W-1];
    assign n_pacc    = mod_dbl_add(r_pacc, mul_bit ? r_acc : '0, r_modulus);
    assign n_pbase   = mod_dbl_add(r_pbase, mul_bit ? r_base : '0, r_modulus);

    // Modulus register: the user must write it only while the block is idle; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= pom_pkg::MODULUS_RESET;
        end else if (i_cfg_valid) begin
            r_modulus <= i_cfg_data;
        end
    end

    // Square-and-multiply working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // A modulus below two gives zero: skip the scan altogether
            r_exp  <= mod_small ? '0 : i_exponent[SCAN_BITS-1:0];
            r_acc  <= mod_small ? '0 : pom_pkg::VAL_W'(1);
            r_base <= (r_modulus == pom_pkg::VAL_W'(2)) ? '0 : pom_pkg::VAL_W'(2);
        end
        if (i_cmd.mul_start) begin
            r_pacc  <= '0;
            r_pbase <= '0;
            r_shift <= r_base;
        end
        if (i_cmd.mul_step) begin
            r_pacc  <= n_pacc;
            r_pbase <= n_pbase;
            r_shift <= {r_shift[pom_pkg::VAL_W-2:0], 1'b0};
        end
        if (i_cmd.commit) begin
            if (r_exp[0]) begin
                r_acc <= r_pacc;
            end
            r_base <= r_pbase;
            r_exp  <= r_exp >> 1;
        end
    end

    // Output register: hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_data <= r_acc;
        end
    end

    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

// ===== src/pom_ctrl.sv =====
`timescale 1ns / 1ps

module pom_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pom_pkg::t_status  i_status,
    output pom_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_MUL,
        S_COMMIT,
        S_FINISH
    } t_state;

    t_state                    r_state;
    logic [pom_pkg::CNT_W-1:0] r_cnt;

    // Sequence the scan: one pair of products per exponent bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (i_status.exp_zero) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_cnt   <= pom_pkg::CNT_W'(pom_pkg::VAL_W - 1);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    r_state <= S_STEP;
                end
                S_FINISH: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Decode commands from the current state
    always_comb begin
        o_cmd           = '0;
        o_in_ready      = (r_state == S_IDLE);
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_start = (r_state == S_STEP) && !i_status.exp_zero;
        o_cmd.mul_step  = (r_state == S_MUL);
        o_cmd.commit    = (r_state == S_COMMIT);
        o_cmd.push      = (r_state == S_FINISH) && i_status.out_free;
    end

endmodule

// ===== src/power_of_two_mod_unit.sv =====
`timescale 1ns / 1ps

// Computes two to the power of the incoming exponent, reduced by the modulus
// register (reset value 1000000007), by right-to-left square-and-multiply.
// For each exponent bit up to the highest set one, the running product and
// the squared base are formed together by one bit-serial interleaved modular
// multiplier that takes one multiplier bit per cycle over 31 bits. One item
// is worked on at a time; the result sits in an output register, so the next
// exponent is taken while it waits. A modulus below two gives zero. Write the
// modulus only while no item is in flight.

module power_of_two_mod_unit #(
    parameter int EXPONENT_BITS = pom_pkg::EXPONENT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: modulus
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pom_pkg::VAL_W-1:0]   i_cfg_data,
    // Input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pom_pkg::DATA_W-1:0]  s_tdata,  // [30:0] exponent, [31] pad
    // Output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pom_pkg::DATA_W-1:0]  m_tdata   // [30:0] power_result, [31] zero
);

    pom_pkg::t_cmd             cmd;
    pom_pkg::t_status          status;
    logic [pom_pkg::VAL_W-1:0] out_data;
    logic                      in_ready;

    pom_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pom_dp #(
        .EXPONENT_BITS (EXPONENT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_exponent  (s_tdata[pom_pkg::VAL_W-1:0]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_out_data  (out_data)
    );

    assign o_cfg_ready = 1'b1;
    assign s_tready    = in_ready;
    assign m_tdata     = {{(pom_pkg::DATA_W - pom_pkg::VAL_W){1'b0}}, out_data};

endmodule

// ===== tb/power_of_two_mod_unit_test.sv =====
`timescale 1ns / 1ps

module power_of_two_mod_unit_test;

    localparam int VAL_W      = pom_pkg::VAL_W;
    localparam int DATA_W     = pom_pkg::DATA_W;
    localparam int EXP_BITS   = pom_pkg::EXPONENT_BITS_DEF;
    localparam int PHASES     = 9;
    localparam int PHASE_ITEMS = 30;
    localparam int LONG_HOLD  = 2500;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT = 1100;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [VAL_W-1:0]    i_cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;   // [30:0] exponent, [31] pad
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;   // [30:0] power_result, [31] zero

    // Pending exponents, and expected powers in order of acceptance
    logic [VAL_W-1:0]    exponent_queue[$];
    logic [VAL_W-1:0]    power_queue[$];
    logic [VAL_W-1:0]    modulus_copy;
    int                  exponents_queued;
    int                  exponents_taken;
    int                  error_count;
    int                  idle_cycles;
    int                  send_gap;
    int                  recv_stall;
    int                  hold_left;
    bit                  calm;
    bit                  hold_request;
    bit                  hold_done;

    power_of_two_mod_unit #(
        .EXPONENT_BITS (EXP_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Two to the power e modulo m, square-and-multiply from the lowest bit
    function automatic logic [VAL_W-1:0] pow2_mod_predict(input logic [VAL_W-1:0] e,
                                                          input logic [VAL_W-1:0] m);
        logic [63:0] acc;
        logic [63:0] base;
        logic [63:0] mm;
        int          i;
        if (m < 2) begin
            return '0;
        end
        mm   = 64'(m);
        acc  = 64'd1;
        base = 64'd2 % mm;
        for (i = 0; i < EXP_BITS && i < VAL_W; i++) begin
            if (e[i]) begin
                acc = (acc * base) % mm;
            end
            base = (base * base) % mm;
        end
        return acc[VAL_W-1:0];
    endfunction

    // Mix of full-width, short, single-bit and all-ones exponents
    function automatic logic [VAL_W-1:0] random_exponent();
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                return VAL_W'($urandom);
            end
            3: begin
                return VAL_W'($urandom_range(0, 40));
            end
            4: begin
                return VAL_W'(1) << $urandom_range(0, VAL_W - 1);
            end
            default: begin
                return {VAL_W{1'b1}} >> $urandom_range(0, VAL_W - 1);
            end
        endcase
    endfunction

    task automatic add_exponent(input logic [VAL_W-1:0] e);
        exponent_queue.push_back(e);
        exponents_queued++;
    endtask

    // Hold until every queued request has been taken and answered
    task automatic wait_idle();
        while (exponents_taken != exponents_queued || power_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_modulus(input logic [VAL_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        modulus_copy = value;
    endtask

    // Input driver: offer queued exponents, with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                power_queue.push_back(pow2_mod_predict(s_tdata[VAL_W-1:0], modulus_copy));
                exponents_taken++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the current request
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (exponent_queue.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, exponent_queue.pop_front()};
                if (!calm && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(1, 4);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor: compare each result, drive back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (power_queue.size() == 0) begin
                    $error("unexpected result: power_result actual %0d", m_tdata[VAL_W-1:0]);
                    error_count++;
                end else if (m_tdata[VAL_W-1:0] !== power_queue[0]) begin
                    $error("mismatch on power_result: expected %0d, actual %0d",
                           power_queue[0], m_tdata[VAL_W-1:0]);
                    error_count++;
                    void'(power_queue.pop_front());
                end else begin
                    void'(power_queue.pop_front());
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_tready  <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                recv_stall = $urandom_range(0, 3);
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run after a long stretch with no handshake
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial begin
        logic [VAL_W-1:0] mod_value;
        int               phase;
        int               n;

        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = '0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        m_tready         = 1'b0;
        modulus_copy     = pom_pkg::MODULUS_RESET;
        exponents_queued = 0;
        exponents_taken  = 0;
        error_count      = 0;
        idle_cycles      = 0;
        send_gap         = 0;
        recv_stall       = 0;
        hold_left        = 0;
        calm             = 1'b0;
        hold_request     = 1'b0;
        hold_done        = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default modulus: zero exponent, field extremes, Fermat case
        add_exponent('0);
        add_exponent(VAL_W'(1));
        add_exponent(VAL_W'(2));
        add_exponent(VAL_W'(30));
        add_exponent(VAL_W'(31));
        add_exponent(VAL_W'(1000000006));
        add_exponent({VAL_W{1'b1}});
        add_exponent(VAL_W'(31'h4000_0000));
        add_exponent(VAL_W'(31'h2AAA_AAAA));
        add_exponent(VAL_W'(31'h5555_5555));
        wait_idle();

        // Smallest meaningful modulus
        write_modulus(VAL_W'(2));
        add_exponent('0);
        add_exponent(VAL_W'(1));
        wait_idle();

        // Largest modulus: two to the 31 wraps to one
        write_modulus({VAL_W{1'b1}});
        add_exponent(VAL_W'(31));
        add_exponent({VAL_W{1'b1}});
        wait_idle();

        // Modulus of zero and of one give zero, even for a zero exponent
        write_modulus('0);
        add_exponent('0);
        add_exponent(VAL_W'(9));
        wait_idle();
        write_modulus(VAL_W'(1));
        add_exponent('0);
        add_exponent(VAL_W'(4));
        wait_idle();

        write_modulus(VAL_W'(3));
        add_exponent(VAL_W'(1));
        add_exponent(VAL_W'(2));
        add_exponent({VAL_W{1'b1}});
        wait_idle();

        // Random phases, one modulus setting each
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: mod_value = VAL_W'($urandom_range(2, 32'h7FFF_FFFF));
                1: mod_value = {VAL_W{1'b1}};
                2: mod_value = VAL_W'($urandom_range(2, 1000));
                3: mod_value = VAL_W'(2);
                4: mod_value = VAL_W'(31'h4000_0000);
                5: mod_value = VAL_W'($urandom_range(2, 32'h7FFF_FFFF)) & ~VAL_W'(1);
                6: mod_value = VAL_W'($urandom_range(0, 1));
                7: mod_value = VAL_W'($urandom_range(2, 32'h7FFF_FFFF)) | VAL_W'(1);
                default: mod_value = pom_pkg::MODULUS_RESET;
            endcase
            write_modulus(mod_value);
            if (phase == PHASES - 1) begin
                calm = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                add_exponent(random_exponent());
            end
            // Stall the receiver long enough that the input backs up
            if (phase == 2) begin
                hold_request = 1'b1;
            end
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0 && power_queue.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
